### rtl/core/ihc_pkg.sv
package ihc_pkg;

    // header size limits in bytes
    localparam int MIN_HEADER_BYTES = 20;
    localparam int MAX_HEADER_BYTES = 60;

    // result queue between the parser and the output stage
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // checksum accumulator width
    localparam int SUM_W = 21;

    // verdict codes
    typedef enum logic [3:0] {
        ST_OK           = 4'd0,
        ST_HDR_SHORT    = 4'd1,
        ST_VERSION      = 4'd2,
        ST_HDR_LONG     = 4'd3,
        ST_TOTAL_LT_HDR = 4'd4,
        ST_RESERVED     = 4'd5,
        ST_FLAGS        = 4'd6,
        ST_TTL_ZERO     = 4'd7,
        ST_SRC_EQ_DST   = 4'd8,
        ST_SRC_BCAST    = 4'd9,
        ST_SRC_MCAST    = 4'd10,
        ST_SRC_RSVD     = 4'd11,
        ST_DST_RSVD     = 4'd12,
        ST_TRUNCATED    = 4'd13,
        ST_CHECKSUM     = 4'd14
    } t_status;

    // extracted header fields
    typedef struct packed {
        logic [7:0]  protocol;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [5:0]  header_len;
        logic [15:0] ip_length;
        logic [7:0]  ttl;
        logic [5:0]  dscp;
        logic [1:0]  ecn;
        logic        df_flag;
        logic        more_fragments;
        logic [12:0] fragment_offset;
    } t_fields;

    // one queued verdict: status, checksum still to judge, raw sum, fields
    typedef struct packed {
        t_status           status;
        logic              chk;
        logic [SUM_W-1:0]  sum;
        t_fields           fields;
    } t_job;

endpackage

### rtl/core/ihc_if.sv
// byte stream into the checker
interface ihc_byte_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] frame_len;

    modport source (output valid, data_byte, first_byte, last_byte, frame_len, input ready);
    modport sink   (input valid, data_byte, first_byte, last_byte, frame_len, output ready);
endinterface

// one verdict per frame out of the checker
interface ihc_verdict_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [7:0]  protocol;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [5:0]  header_len;
    logic [15:0] ip_length;
    logic [7:0]  ttl;
    logic [5:0]  dscp;
    logic [1:0]  ecn;
    logic        df_flag;
    logic        more_fragments;
    logic [12:0] fragment_offset;

    modport source (
        output valid, status, protocol, source_ip, dest_ip, header_len, ip_length,
               ttl, dscp, ecn, df_flag, more_fragments, fragment_offset,
        input  ready
    );
    modport sink (
        input  valid, status, protocol, source_ip, dest_ip, header_len, ip_length,
               ttl, dscp, ecn, df_flag, more_fragments, fragment_offset,
        output ready
    );
endinterface

### rtl/core/ipv4_header_checker.sv
// Streaming IPv4 header checker. Frame bytes enter on i_byte, one item per
// clock, header first; first_byte opens a frame and samples frame_len, and
// bytes that arrive outside a frame are dropped. Each frame yields exactly one
// verdict on o_verdict: at the first failed check, or at the last header byte,
// carrying the status code and the header fields seen so far (fields not yet
// received read as zero). A new first_byte abandons a frame in progress with no
// verdict. The parser takes one byte per cycle with no bubbles; the only stall
// comes from the two-entry verdict queue filling while o_verdict is held off.
// The checksum is folded and judged in the output stage; a verdict passes
// through the verdict queue, then the output register. MAX_HDR_BYTES sets the
// longest header accepted before a header-long verdict.
module ipv4_header_checker #(
    parameter int MAX_HDR_BYTES = ihc_pkg::MAX_HEADER_BYTES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ihc_byte_if.sink      i_byte,
    ihc_verdict_if.source o_verdict
);
    import ihc_pkg::*;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_job push_job;
    t_job head_job;

    // byte parser and checks
    ihc_front #(
        .MAX_HDR_BYTES (MAX_HDR_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (i_byte),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_job    (push_job)
    );

    // verdict queue
    ihc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    // checksum judgment and output register
    ihc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (head_job),
        .o_pop     (q_pop),
        .o_verdict (o_verdict)
    );

endmodule

### rtl/core/ihc_front.sv
module ihc_front #(
    parameter int MAX_HDR_BYTES = ihc_pkg::MAX_HEADER_BYTES
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ihc_byte_if.sink     i_byte,
    input  logic         i_q_full,
    output logic         o_push,
    output ihc_pkg::t_job o_job
);
    import ihc_pkg::*;

    // header byte offsets
    localparam logic [5:0] IDX_VER_IHL  = 6'd0;
    localparam logic [5:0] IDX_TOS      = 6'd1;
    localparam logic [5:0] IDX_TOT_HI   = 6'd2;
    localparam logic [5:0] IDX_TOT_LO   = 6'd3;
    localparam logic [5:0] IDX_FRAG_HI  = 6'd6;
    localparam logic [5:0] IDX_FRAG_LO  = 6'd7;
    localparam logic [5:0] IDX_TTL      = 6'd8;
    localparam logic [5:0] IDX_PROTO    = 6'd9;
    localparam logic [5:0] IDX_SRC0     = 6'd12;
    localparam logic [5:0] IDX_SRC1     = 6'd13;
    localparam logic [5:0] IDX_SRC2     = 6'd14;
    localparam logic [5:0] IDX_SRC3     = 6'd15;
    localparam logic [5:0] IDX_DST0     = 6'd16;
    localparam logic [5:0] IDX_DST1     = 6'd17;
    localparam logic [5:0] IDX_DST2     = 6'd18;
    localparam logic [5:0] IDX_DST3     = 6'd19;

    logic             r_busy, n_busy;
    logic [5:0]       r_byte_index, n_byte_index;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [7:0]       r_low, n_low;
    logic [15:0]      r_frame_len, n_frame_len;
    t_fields          r_fields, n_fields;

    logic             accept;
    logic             emit;
    logic             chk;
    logic             loopback;
    logic [5:0]       idx;
    logic [5:0]       hlen;
    logic [7:0]       b;
    t_status          st;

    assign i_byte.ready = !i_q_full;
    assign accept       = i_byte.valid && !i_q_full;
    assign b            = i_byte.data_byte;

    // per-byte parse, checks and checksum accumulation
    always_comb begin
        n_busy       = r_busy;
        n_byte_index = r_byte_index;
        n_sum        = r_sum;
        n_low        = r_low;
        n_frame_len  = r_frame_len;
        n_fields     = r_fields;
        emit         = 1'b0;
        chk          = 1'b0;
        st           = ST_OK;
        loopback     = 1'b0;
        idx          = r_byte_index;
        hlen         = r_fields.header_len;
        if (accept) begin
            if (i_byte.first_byte) begin
                n_busy       = 1'b1;
                n_byte_index = '0;
                n_sum        = '0;
                n_low        = '0;
                n_fields     = '0;
                n_frame_len  = i_byte.frame_len;
                idx          = '0;
            end
            if (i_byte.first_byte && (i_byte.frame_len < 16'(MIN_HEADER_BYTES))) begin
                emit = 1'b1;
                st   = ST_HDR_SHORT;
            end else if (n_busy) begin
                // words are odd byte high, even byte low
                if (idx[0]) begin
                    n_sum = n_sum + {{(SUM_W-16){1'b0}}, b, n_low};
                end else begin
                    n_low = b;
                end

                case (idx)
                    IDX_VER_IHL: begin
                        n_fields.header_len = {b[3:0], 2'b00};
                        if (b[7:4] != 4'd4) begin
                            st = ST_VERSION;
                        end else if (n_fields.header_len < 6'(MIN_HEADER_BYTES)) begin
                            st = ST_HDR_SHORT;
                        end else if (n_fields.header_len > 6'(MAX_HDR_BYTES)) begin
                            st = ST_HDR_LONG;
                        end
                    end
                    IDX_TOS: begin
                        n_fields.dscp = b[7:2];
                        n_fields.ecn  = b[1:0];
                    end
                    IDX_TOT_HI: begin
                        n_fields.ip_length = {b, 8'h00};
                    end
                    IDX_TOT_LO: begin
                        n_fields.ip_length = {n_fields.ip_length[15:8], b};
                        if (n_fields.ip_length < {10'd0, n_fields.header_len}) begin
                            st = ST_TOTAL_LT_HDR;
                        end
                    end
                    IDX_FRAG_HI: begin
                        n_fields.df_flag         = b[6];
                        n_fields.more_fragments  = b[5];
                        n_fields.fragment_offset = {b[4:0], 8'h00};
                        if (b[7]) begin
                            st = ST_RESERVED;
                        end else if (b[6] && b[5]) begin
                            st = ST_FLAGS;
                        end
                    end
                    IDX_FRAG_LO: begin
                        n_fields.fragment_offset = {n_fields.fragment_offset[12:8], b};
                    end
                    IDX_TTL: begin
                        n_fields.ttl = b;
                        if (b == 8'd0) begin
                            st = ST_TTL_ZERO;
                        end
                    end
                    IDX_PROTO: begin
                        n_fields.protocol = b;
                    end
                    IDX_SRC0: n_fields.source_ip[31:24] = b;
                    IDX_SRC1: n_fields.source_ip[23:16] = b;
                    IDX_SRC2: n_fields.source_ip[15:8]  = b;
                    IDX_SRC3: n_fields.source_ip[7:0]   = b;
                    IDX_DST0: n_fields.dest_ip[31:24] = b;
                    IDX_DST1: n_fields.dest_ip[23:16] = b;
                    IDX_DST2: n_fields.dest_ip[15:8]  = b;
                    IDX_DST3: begin
                        n_fields.dest_ip[7:0] = b;
                        // address class checks once both addresses are in
                        loopback = (n_fields.source_ip[31:24] == 8'd127) ||
                                   (n_fields.dest_ip[31:24] == 8'd127);
                        if (!loopback && (n_fields.source_ip == n_fields.dest_ip)) begin
                            st = ST_SRC_EQ_DST;
                        end else if (n_fields.source_ip == 32'hFFFF_FFFF) begin
                            st = ST_SRC_BCAST;
                        end else if (n_fields.source_ip[31:28] == 4'hE) begin
                            st = ST_SRC_MCAST;
                        end else if (n_fields.source_ip[31:28] == 4'hF) begin
                            st = ST_SRC_RSVD;
                        end else if (n_fields.dest_ip[31:28] == 4'hF) begin
                            st = ST_DST_RSVD;
                        end
                    end
                    default: begin
                    end
                endcase

                hlen = n_fields.header_len;
                if (st != ST_OK) begin
                    emit = 1'b1;
                end else if ((idx >= IDX_DST3) && ({1'b0, idx} + 7'd1 >= {1'b0, hlen})) begin
                    // header end: length check here, checksum judged downstream
                    emit = 1'b1;
                    if (n_frame_len < n_fields.ip_length) begin
                        st = ST_TRUNCATED;
                    end else begin
                        chk = 1'b1;
                    end
                end else if (i_byte.last_byte) begin
                    emit = 1'b1;
                    st   = ST_TRUNCATED;
                end else begin
                    n_byte_index = idx + 6'd1;
                end
            end
            if (emit) begin
                n_busy = 1'b0;
            end
        end
    end

    assign o_push        = emit;
    assign o_job.status  = st;
    assign o_job.chk     = chk;
    assign o_job.sum     = n_sum;
    assign o_job.fields  = n_fields;

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_byte_index <= '0;
            r_sum        <= '0;
            r_low        <= '0;
            r_frame_len  <= '0;
            r_fields     <= '0;
        end else begin
            r_busy       <= n_busy;
            r_byte_index <= n_byte_index;
            r_sum        <= n_sum;
            r_low        <= n_low;
            r_frame_len  <= n_frame_len;
            r_fields     <= n_fields;
        end
    end

`ifndef SYNTHESIS
    // a verdict leaves the parser idle until the next first byte
    a_idle_after_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> !r_busy)
        else $error("parser still busy after verdict");

    // the header end is always reached before the index runs past the largest header
    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_byte_index < 6'(MAX_HDR_BYTES)))
        else $error("byte index beyond largest header");
`endif

endmodule

### rtl/core/ihc_queue.sv
module ihc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ihc_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output ihc_pkg::t_job o_job
);
    import ihc_pkg::*;

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_count, n_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

`ifndef SYNTHESIS
    // the parser never pushes a verdict into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("verdict pushed into full queue");

    // fill count stays within depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

### rtl/core/ihc_back.sv
module ihc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  ihc_pkg::t_job i_q_job,
    output logic          o_pop,
    ihc_verdict_if.source o_verdict
);
    import ihc_pkg::*;

    logic        r_valid, n_valid;
    t_fields     r_fields;
    t_status     r_status;
    t_status     final_status;
    logic [16:0] fold1;
    logic [16:0] fold2;

    // end-around carry fold of the header sum
    assign fold1 = {1'b0, i_q_job.sum[15:0]} + {12'd0, i_q_job.sum[SUM_W-1:16]};
    assign fold2 = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};

    always_comb begin
        final_status = i_q_job.status;
        if (i_q_job.chk) begin
            final_status = (fold2 == 17'h0FFFF) ? ST_OK : ST_CHECKSUM;
        end
    end

    // output register, refilled whenever it is empty or being taken
    assign o_pop = i_q_valid && (!r_valid || o_verdict.ready);

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (o_verdict.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status <= final_status;
            r_fields <= i_q_job.fields;
        end
    end

    assign o_verdict.valid           = r_valid;
    assign o_verdict.status          = r_status;
    assign o_verdict.protocol        = r_fields.protocol;
    assign o_verdict.source_ip       = r_fields.source_ip;
    assign o_verdict.dest_ip         = r_fields.dest_ip;
    assign o_verdict.header_len      = r_fields.header_len;
    assign o_verdict.ip_length       = r_fields.ip_length;
    assign o_verdict.ttl             = r_fields.ttl;
    assign o_verdict.dscp            = r_fields.dscp;
    assign o_verdict.ecn             = r_fields.ecn;
    assign o_verdict.df_flag         = r_fields.df_flag;
    assign o_verdict.more_fragments  = r_fields.more_fragments;
    assign o_verdict.fragment_offset = r_fields.fragment_offset;

endmodule
